// ----- sv/sbas_pkg.sv -----
// ============================================================================
// sbas_pkg: shared types and constants of the striped block address splitter
// Widths of the stream fields, operation and status codes, the controller
// state type and the command and status bundles between the controller
// and the datapath.
// ============================================================================
package sbas_pkg;

    // Field widths.
    localparam int OFS_W      = 48;                 // logical offsets
    localparam int DISP_W     = OFS_W + 1;          // signed offset or displacement
    localparam int LEN_W      = 32;                 // request length
    localparam int PHYS_W     = 58;                 // physical offset
    localparam int SLEN_W     = 31;                 // segment length
    localparam int WITHIN_W   = 30;                 // offset inside a block
    localparam int BSL_W      = 5;
    localparam int CC_W       = 11;
    localparam int CI_W       = 10;
    localparam int OP_W       = 3;
    localparam int STAT_W     = 2;

    // Block size limits and derived block number widths.
    localparam logic [BSL_W-1:0] BSL_MIN = BSL_W'(9);
    localparam logic [BSL_W-1:0] BSL_MAX = BSL_W'(30);
    localparam logic [CC_W-1:0]  CC_MAX  = CC_W'(1024);
    localparam int BLK_W      = OFS_W - 9;          // logical block number
    localparam int PBLK_W     = BLK_W + CC_W + 1;   // physical block number

    // Largest number of segments one transfer may span.
    localparam int MAX_SEGMENTS = 64;

    // Stream and configuration port widths.
    localparam int S_TDATA_W  = 88;
    localparam int S_TUSER_W  = 4;
    localparam int M_TDATA_W  = 192;
    localparam int M_TUSER_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LOG2 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN_COUNT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN_INDEX = CFG_IDX_W'(2);

    // Request operations.
    typedef enum logic [OP_W-1:0] {
        OP_XFER_AT  = 3'd0,
        OP_XFER_POS = 3'd1,
        OP_SEEK_SET = 3'd2,
        OP_SEEK_CUR = 3'd3,
        OP_SEEK_END = 3'd4
    } op_t;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_SPAN  = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SPAN,
        S_MAP,
        S_SEEK,
        S_SEG,
        S_ONE
    } state_t;

    // Effective (clamped) configuration.
    typedef struct packed {
        logic [BSL_W-1:0] block_log2;
        logic [CC_W-1:0]  chan_count;
        logic [CI_W-1:0]  chan_index;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;       // latch the input item
        logic check;        // range check and end offset
        logic span;         // block numbers and span check
        logic map;          // physical block and state commit
        logic seek;         // commit a seek target
        logic load_seg;     // load one segment into the output register
        logic load_one;     // load a single result into the output register
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic range_bad;
        logic span_bad;
        logic is_seek;
        logic seg_last;
        logic out_free;
    } ctrl_sts_t;

endpackage

// ----- sv/sbas_ctrl.sv -----
// ============================================================================
// sbas_ctrl: request sequencer
// Walks each request through check and span steps, then map and segment issue
// or seek and single result steps, and drives the datapath with one command bundle.
// ============================================================================
module sbas_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  sbas_pkg::ctrl_sts_t   sts,
    output sbas_pkg::ctrl_cmd_t   cmd
);

    sbas_pkg::state_t state_reg;
    sbas_pkg::state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sbas_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sbas_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    state_next = sbas_pkg::S_CHECK;
                end
            end
            sbas_pkg::S_CHECK: begin
                state_next = sbas_pkg::S_SPAN;
            end
            sbas_pkg::S_SPAN: begin
                if (sts.range_bad) begin
                    state_next = sbas_pkg::S_ONE;
                end else if (sts.is_seek) begin
                    state_next = sbas_pkg::S_SEEK;
                end else begin
                    state_next = sbas_pkg::S_MAP;
                end
            end
            sbas_pkg::S_MAP: begin
                if (sts.span_bad) begin
                    state_next = sbas_pkg::S_ONE;
                end else begin
                    state_next = sbas_pkg::S_SEG;
                end
            end
            sbas_pkg::S_SEEK: begin
                state_next = sbas_pkg::S_ONE;
            end
            sbas_pkg::S_SEG: begin
                if (sts.out_free && sts.seg_last) begin
                    state_next = sbas_pkg::S_IDLE;
                end
            end
            sbas_pkg::S_ONE: begin
                if (sts.out_free) begin
                    state_next = sbas_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = sbas_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            sbas_pkg::S_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            sbas_pkg::S_CHECK: begin
                cmd.check = 1'b1;
            end
            sbas_pkg::S_SPAN: begin
                cmd.span = !sts.range_bad && !sts.is_seek;
            end
            sbas_pkg::S_MAP: begin
                cmd.map = !sts.span_bad;
            end
            sbas_pkg::S_SEEK: begin
                cmd.seek = 1'b1;
            end
            sbas_pkg::S_SEG: begin
                cmd.load_seg = sts.out_free;
            end
            sbas_pkg::S_ONE: begin
                cmd.load_one = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- sv/sbas_dp.sv -----
// ============================================================================
// sbas_dp: address splitter datapath
// Holds the request, the kept position and extent, computes block numbers
// and the physical block, and issues segments into the output register.
// ============================================================================
module sbas_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  sbas_pkg::cfg_t                    cfg,
    input  sbas_pkg::ctrl_cmd_t               cmd,
    output sbas_pkg::ctrl_sts_t               sts,
    input  logic [sbas_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [sbas_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sbas_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [sbas_pkg::M_TUSER_W-1:0]    m_tuser,
    output logic                              m_tlast
);

    localparam int OFS_W    = sbas_pkg::OFS_W;
    localparam int DISP_W   = sbas_pkg::DISP_W;
    localparam int LEN_W    = sbas_pkg::LEN_W;
    localparam int PHYS_W   = sbas_pkg::PHYS_W;
    localparam int SLEN_W   = sbas_pkg::SLEN_W;
    localparam int WITHIN_W = sbas_pkg::WITHIN_W;
    localparam int BLK_W    = sbas_pkg::BLK_W;
    localparam int PBLK_W   = sbas_pkg::PBLK_W;
    localparam int CC_W     = sbas_pkg::CC_W;

    // Request registers.
    logic [sbas_pkg::OP_W-1:0]  op_reg;
    logic                       wr_reg;
    logic [DISP_W-1:0]          disp_reg;
    logic [LEN_W-1:0]           len_reg;

    // Kept state.
    logic [OFS_W-1:0]           pos_reg;
    logic [OFS_W-1:0]           ext_reg;

    // Working registers.
    logic [OFS_W-1:0]           start_reg;
    logic [OFS_W-1:0]           end_reg;
    logic [OFS_W-1:0]           target_reg;
    logic                       is_seek_reg;
    sbas_pkg::status_t          status_reg;
    logic [BLK_W-1:0]           blk0_reg;
    logic [WITHIN_W-1:0]        within_reg;
    logic [LEN_W-1:0]           rem_reg;
    logic [PBLK_W-1:0]          pblk_reg;

    // Output register.
    logic                       m_valid_reg;
    logic [PHYS_W-1:0]          o_phys_reg;
    logic [SLEN_W-1:0]          o_len_reg;
    logic                       o_wr_reg;
    logic                       o_last_reg;
    sbas_pkg::status_t          o_status_reg;
    logic [OFS_W-1:0]           o_pos_reg;
    logic [OFS_W-1:0]           o_ext_reg;

    // Check step signals.
    logic [OFS_W-1:0]           chk_start;
    logic                       chk_bad;
    logic                       chk_seek;
    logic [OFS_W-1:0]           seek_base;
    logic [DISP_W:0]            seek_target;
    logic [DISP_W-1:0]          end_sum;

    // Span step signals.
    logic [OFS_W-1:0]           start_shr;
    logic [OFS_W-1:0]           end_m1;
    logic [OFS_W-1:0]           last_shr;
    logic [BLK_W-1:0]           blk_diff;
    logic                       span_over;
    logic [SLEN_W-1:0]          bsz;
    logic [SLEN_W-1:0]          bmask;

    // Map and segment signals.
    logic [BLK_W+CC_W-1:0]      prod;
    logic [SLEN_W-1:0]          take_cap;
    logic [SLEN_W-1:0]          take;
    logic [LEN_W-1:0]           rem_after;
    logic [PHYS_W-1:0]          pblk_shl;
    logic [PHYS_W-1:0]          seg_phys;

    // Range check of the transfer start, end and seek target.
    always_comb begin
        seek_base = '0;
        case (op_reg)
            sbas_pkg::OP_SEEK_CUR: seek_base = pos_reg;
            sbas_pkg::OP_SEEK_END: seek_base = ext_reg;
            default:               seek_base = '0;
        endcase
        seek_target = {2'b00, seek_base} + {disp_reg[DISP_W-1], disp_reg};

        chk_start = pos_reg;
        if (op_reg == sbas_pkg::OP_XFER_AT) begin
            chk_start = disp_reg[OFS_W-1:0];
        end
        end_sum = {1'b0, chk_start} + DISP_W'(len_reg);

        case (op_reg)
            sbas_pkg::OP_XFER_AT: begin
                chk_seek = 1'b0;
                chk_bad  = disp_reg[DISP_W-1] || end_sum[DISP_W-1];
            end
            sbas_pkg::OP_XFER_POS: begin
                chk_seek = 1'b0;
                chk_bad  = end_sum[DISP_W-1];
            end
            sbas_pkg::OP_SEEK_SET, sbas_pkg::OP_SEEK_CUR, sbas_pkg::OP_SEEK_END: begin
                chk_seek = 1'b1;
                chk_bad  = seek_target[DISP_W] || seek_target[DISP_W-1];
            end
            default: begin
                chk_seek = 1'b1;
                chk_bad  = 1'b1;
            end
        endcase
    end

    // Block numbers of the first and last byte, and the span limit.
    always_comb begin
        start_shr = start_reg >> cfg.block_log2;
        end_m1    = end_reg - OFS_W'(1);
        last_shr  = end_m1 >> cfg.block_log2;
        blk_diff  = last_shr[BLK_W-1:0] - start_shr[BLK_W-1:0];
        span_over = (len_reg != '0) && (blk_diff >= BLK_W'(sbas_pkg::MAX_SEGMENTS));
        bsz       = SLEN_W'(1) << cfg.block_log2;
        bmask     = bsz - SLEN_W'(1);
    end

    // Physical block of the first segment, and the current segment.
    always_comb begin
        prod      = {{CC_W{1'b0}}, blk0_reg} * {{BLK_W{1'b0}}, cfg.chan_count};
        take_cap  = bsz - SLEN_W'(within_reg);
        take      = take_cap;
        if (rem_reg < LEN_W'(take_cap)) begin
            take = rem_reg[SLEN_W-1:0];
        end
        rem_after = rem_reg - LEN_W'(take);
        pblk_shl  = {{(PHYS_W-PBLK_W){1'b0}}, pblk_reg} << cfg.block_log2;
        seg_phys  = pblk_shl + PHYS_W'(within_reg);
    end

    // Request latch.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            disp_reg <= s_tdata[DISP_W-1:0];
            len_reg  <= s_tdata[DISP_W+LEN_W-1:DISP_W];
            op_reg   <= s_tuser[sbas_pkg::OP_W-1:0];
            wr_reg   <= s_tuser[sbas_pkg::OP_W];
        end
    end

    // Working registers of the check, span, map and segment steps.
    always_ff @(posedge aclk) begin
        if (cmd.check) begin
            start_reg   <= chk_start;
            end_reg     <= end_sum[OFS_W-1:0];
            target_reg  <= seek_target[OFS_W-1:0];
            is_seek_reg <= chk_seek;
            status_reg  <= chk_bad ? sbas_pkg::STAT_RANGE : sbas_pkg::STAT_OK;
        end
        if (cmd.span) begin
            blk0_reg   <= start_shr[BLK_W-1:0];
            within_reg <= start_reg[WITHIN_W-1:0] & bmask[WITHIN_W-1:0];
            rem_reg    <= len_reg;
            if (span_over) begin
                status_reg <= sbas_pkg::STAT_SPAN;
            end
        end
        if (cmd.map) begin
            pblk_reg <= PBLK_W'(prod) + PBLK_W'(cfg.chan_index);
        end
        if (cmd.load_seg) begin
            pblk_reg   <= pblk_reg + PBLK_W'(cfg.chan_count);
            within_reg <= '0;
            rem_reg    <= rem_after;
        end
    end

    // Kept position and extent.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            ext_reg <= '0;
        end else begin
            if (cmd.seek) begin
                pos_reg <= target_reg;
            end
            if (cmd.map) begin
                if (op_reg == sbas_pkg::OP_XFER_POS) begin
                    pos_reg <= end_reg;
                end
                if (ext_reg < end_reg) begin
                    ext_reg <= end_reg;
                end
            end
        end
    end

    // Output valid: set on a load, cleared when the result is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_seg || cmd.load_one) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge aclk) begin
        if (cmd.load_seg) begin
            o_phys_reg   <= seg_phys;
            o_len_reg    <= take;
            o_wr_reg     <= wr_reg;
            o_last_reg   <= (rem_after == '0);
            o_status_reg <= sbas_pkg::STAT_OK;
            o_pos_reg    <= pos_reg;
            o_ext_reg    <= ext_reg;
        end else if (cmd.load_one) begin
            o_phys_reg   <= '0;
            o_len_reg    <= '0;
            o_wr_reg     <= wr_reg && !is_seek_reg;
            o_last_reg   <= 1'b1;
            o_status_reg <= status_reg;
            o_pos_reg    <= pos_reg;
            o_ext_reg    <= ext_reg;
        end
    end

    // Status to the controller.
    always_comb begin
        sts.range_bad = (status_reg == sbas_pkg::STAT_RANGE);
        sts.span_bad  = (status_reg == sbas_pkg::STAT_SPAN);
        sts.is_seek   = is_seek_reg;
        sts.seg_last  = (rem_after == '0);
        sts.out_free  = !m_valid_reg || m_tready;
    end

    // Result channel.
    assign m_tvalid = m_valid_reg;
    assign m_tlast  = o_last_reg;
    assign m_tuser  = {o_status_reg, o_wr_reg};
    assign m_tdata  = {{(sbas_pkg::M_TDATA_W - PHYS_W - SLEN_W - 2*OFS_W){1'b0}},
                       o_ext_reg, o_pos_reg, o_len_reg, o_phys_reg};

endmodule

// ----- sv/striped_block_address_splitter_top.sv -----
// ============================================================================
// striped_block_address_splitter_top: striped block address splitter
// Splits transfer requests into block-bounded segments and maps each onto
// this participant's slot of a round-robin striped store; handles seeks.
//
//   channel   direction  handshake           contents
//   s_        in         s_tvalid/s_tready   one request
//   m_        out        m_tvalid/m_tready   one segment or single result
//   cfg_      in         cfg_valid/cfg_ready one register write
//
// A request is taken while idle, then passes the check and span steps and,
// for a transfer, the map step; a transfer then issues one segment a cycle
// while the output register is free. A seek takes a seek step in place of
// the map step; a seek or a rejected request gives a single result.
// The segment rate is set by the single output register, and the physical
// block of the first segment by one multiplier stage.
// Reset is synchronous, active low; it clears position, extent, output valid
// and state, sets the config defaults. A stall on m_tready holds segment issue.
// ============================================================================
module striped_block_address_splitter_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Request channel.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // tdata: offset_value[48:0], request_length[80:49], zero fill up to 87.
    input  logic [sbas_pkg::S_TDATA_W-1:0]       s_tdata,
    // tuser: operation[2:0], is_write[3].
    input  logic [sbas_pkg::S_TUSER_W-1:0]       s_tuser,
    // Result channel.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // tdata: physical_offset[57:0], segment_length[88:58], position_now[136:89],
    // size_now[184:137], zero fill up to 191.
    output logic [sbas_pkg::M_TDATA_W-1:0]       m_tdata,
    // tuser: segment_write[0], status[2:1].
    output logic [sbas_pkg::M_TUSER_W-1:0]       m_tuser,
    // tlast: last_segment.
    output logic                                 m_tlast,
    // Configuration write channel.
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sbas_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sbas_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic [sbas_pkg::BSL_W-1:0] block_log2_reg;
    logic [sbas_pkg::CC_W-1:0]  chan_count_reg;
    logic [sbas_pkg::CI_W-1:0]  chan_index_reg;

    sbas_pkg::cfg_t      cfg_eff;
    sbas_pkg::ctrl_cmd_t cmd;
    sbas_pkg::ctrl_sts_t sts;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_log2_reg <= sbas_pkg::BSL_W'(23);
            chan_count_reg <= sbas_pkg::CC_W'(1);
            chan_index_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                sbas_pkg::CFG_BLOCK_LOG2: block_log2_reg <= cfg_data[sbas_pkg::BSL_W-1:0];
                sbas_pkg::CFG_CHAN_COUNT: chan_count_reg <= cfg_data[sbas_pkg::CC_W-1:0];
                sbas_pkg::CFG_CHAN_INDEX: chan_index_reg <= cfg_data[sbas_pkg::CI_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Clamp the registers to their usable ranges.
    always_comb begin
        cfg_eff.block_log2 = block_log2_reg;
        if (block_log2_reg < sbas_pkg::BSL_MIN) begin
            cfg_eff.block_log2 = sbas_pkg::BSL_MIN;
        end else if (block_log2_reg > sbas_pkg::BSL_MAX) begin
            cfg_eff.block_log2 = sbas_pkg::BSL_MAX;
        end

        cfg_eff.chan_count = chan_count_reg;
        if (chan_count_reg == '0) begin
            cfg_eff.chan_count = sbas_pkg::CC_W'(1);
        end else if (chan_count_reg > sbas_pkg::CC_MAX) begin
            cfg_eff.chan_count = sbas_pkg::CC_MAX;
        end

        cfg_eff.chan_index = chan_index_reg;
        if (sbas_pkg::CC_W'(chan_index_reg) >= cfg_eff.chan_count) begin
            cfg_eff.chan_index = sbas_pkg::CI_W'(cfg_eff.chan_count - sbas_pkg::CC_W'(1));
        end
    end

    sbas_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sbas_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_eff),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- verif/testbench.sv -----
// ============================================================================
// testbench: regression for the striped block address splitter
// Drives requests on the s_ stream and checks every segment on the m_ stream
// against an in-bench prediction of positions, extents and striped offsets.
// A directed set covers the range and span limits, seeks and bad operations.
// Random phases follow, each under a new register setting (clamped values
// included), with random idling on both sides and one long receiver stall.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OFS_W      = sbas_pkg::OFS_W;
    localparam int DISP_W     = sbas_pkg::DISP_W;
    localparam int LEN_W      = sbas_pkg::LEN_W;
    localparam int PHYS_W     = sbas_pkg::PHYS_W;
    localparam int SLEN_W     = sbas_pkg::SLEN_W;
    localparam int OP_W       = sbas_pkg::OP_W;
    localparam int BSL_W      = sbas_pkg::BSL_W;
    localparam int CC_W       = sbas_pkg::CC_W;
    localparam int CI_W       = sbas_pkg::CI_W;
    localparam int S_TDATA_W  = sbas_pkg::S_TDATA_W;
    localparam int S_TUSER_W  = sbas_pkg::S_TUSER_W;
    localparam int M_TDATA_W  = sbas_pkg::M_TDATA_W;
    localparam int M_TUSER_W  = sbas_pkg::M_TUSER_W;
    localparam int CFG_IDX_W  = sbas_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = sbas_pkg::CFG_DATA_W;

    localparam longint MAX_POS          = (64'd1 << OFS_W) - 1;
    localparam longint DEFAULT_BLOCK    = 8388608;
    localparam int     LONG_HOLD_CYCLES = 400;
    localparam int     DRAIN_CYCLES     = 16;
    localparam int     RANDOM_PHASES    = 7;
    localparam int     ITEMS_PER_PHASE  = 18;

    // One request as it travels on the s_ stream.
    typedef struct {
        logic [OP_W-1:0]          op;
        logic                     wr;
        logic signed [DISP_W-1:0] ofs;
        logic [LEN_W-1:0]         len;
    } request_t;

    // One result as it travels on the m_ stream.
    typedef struct {
        logic [PHYS_W-1:0]  phys;
        logic [SLEN_W-1:0]  seg_len;
        logic               seg_wr;
        logic               last;
        sbas_pkg::status_t  status;
        logic [OFS_W-1:0]   pos;
        logic [OFS_W-1:0]   size;
    } segment_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Pending requests and the segments they are predicted to produce.
    request_t request_queue[$];
    segment_t expected_segments[$];
    request_t offered;

    // Mirror of the block's registers and kept state.
    logic [BSL_W-1:0] cfg_log2;
    logic [CC_W-1:0]  cfg_count;
    logic [CI_W-1:0]  cfg_chan;
    logic [OFS_W-1:0] position_model;
    logic [OFS_W-1:0] extent_model;

    // Idling controls, set per phase by the sequencer.
    int send_gap_max  = 0;
    int recv_gap_max  = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int send_gap      = 0;
    int recv_gap      = 0;
    int hold_left     = 0;

    int requests_accepted  = 0;
    int results_checked    = 0;
    int rejected_requests  = 0;
    int spanning_requests  = 0;
    int settings_applied   = 0;
    int error_count        = 0;

    striped_block_address_splitter_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock generation, 8 ns period.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Block size exponent after clamping to the supported range.
    function automatic int block_log2_now();
        if (cfg_log2 < sbas_pkg::BSL_MIN) return sbas_pkg::BSL_MIN;
        if (cfg_log2 > sbas_pkg::BSL_MAX) return sbas_pkg::BSL_MAX;
        return cfg_log2;
    endfunction

    // Queues one expected result, stamped with the kept position and extent.
    function automatic void push_segment(logic [63:0] phys, logic [63:0] len, logic wr,
                                         logic last, sbas_pkg::status_t st);
        segment_t seg;
        seg.phys    = phys[PHYS_W-1:0];
        seg.seg_len = len[SLEN_W-1:0];
        seg.seg_wr  = wr;
        seg.last    = last;
        seg.status  = st;
        seg.pos     = position_model;
        seg.size    = extent_model;
        expected_segments.push_back(seg);
    endfunction

    // Works out the results of one accepted request and updates the mirror.
    function automatic void predict_request(request_t r);
        longint    disp;
        longint    target;
        longint    start;
        longint    len;
        int        b;
        bit [63:0] bsz, cc, ci, s, e, nseg, cur, blk, blk_off, take;
        int        k;
        disp = r.ofs;
        len  = r.len;
        // Seeks, and operations outside the known set, give a single result.
        if (r.op >= sbas_pkg::OP_SEEK_SET) begin
            case (r.op)
                sbas_pkg::OP_SEEK_SET: target = disp;
                sbas_pkg::OP_SEEK_CUR: target = longint'(position_model) + disp;
                sbas_pkg::OP_SEEK_END: target = longint'(extent_model) + disp;
                default:               target = -1;
            endcase
            if (target < 0 || target > MAX_POS) begin
                rejected_requests++;
                push_segment(64'd0, 64'd0, 1'b0, 1'b1, sbas_pkg::STAT_RANGE);
            end else begin
                position_model = target[OFS_W-1:0];
                push_segment(64'd0, 64'd0, 1'b0, 1'b1, sbas_pkg::STAT_OK);
            end
            return;
        end
        start = (r.op == sbas_pkg::OP_XFER_AT) ? disp : longint'(position_model);
        if (start < 0 || start > MAX_POS || start + len > MAX_POS) begin
            rejected_requests++;
            push_segment(64'd0, 64'd0, r.wr, 1'b1, sbas_pkg::STAT_RANGE);
            return;
        end
        b   = block_log2_now();
        bsz = 64'd1 << b;
        cc  = cfg_count;
        if (cc == 0) cc = 1;
        if (cc > sbas_pkg::CC_MAX) cc = sbas_pkg::CC_MAX;
        ci = cfg_chan;
        if (ci >= cc) ci = cc - 1;
        s = start;
        e = s + len;
        nseg = (len == 0) ? 1 : (((e - 1) >> b) - (s >> b) + 1);
        if (nseg > sbas_pkg::MAX_SEGMENTS) begin
            rejected_requests++;
            push_segment(64'd0, 64'd0, r.wr, 1'b1, sbas_pkg::STAT_SPAN);
            return;
        end
        if (nseg > 1) spanning_requests++;
        // State commits before the segments go out; they all carry the new values.
        if (r.op == sbas_pkg::OP_XFER_POS) position_model = e[OFS_W-1:0];
        if (extent_model < e) extent_model = e[OFS_W-1:0];
        cur = s;
        for (k = 0; k < nseg; k++) begin
            blk     = cur >> b;
            blk_off = cur & (bsz - 1);
            take    = bsz - blk_off;
            if (take > e - cur) take = e - cur;
            push_segment(((blk * cc + ci) << b) + blk_off, take, r.wr,
                         k == nseg - 1, sbas_pkg::STAT_OK);
            cur += take;
        end
    endfunction

    function automatic void queue_request(logic [OP_W-1:0] op, logic wr, longint ofs,
                                          longint len);
        request_t r;
        r.op  = op;
        r.wr  = wr;
        r.ofs = ofs[DISP_W-1:0];
        r.len = len[LEN_W-1:0];
        request_queue.push_back(r);
    endfunction

    // Random request shaped by the current block size: mostly legal transfers
    // near block boundaries, some seeks, and a share of out-of-range noise.
    function automatic request_t random_request();
        request_t r;
        int       b;
        longint   bsz;
        longint   start;
        longint   len;
        int       kind;
        b   = block_log2_now();
        bsz = longint'(1) << b;
        case ($urandom_range(0, 9))
            0:             len = 0;
            1, 2, 3, 4, 5: len = $urandom_range(1, 32'(2 * bsz));
            6:             len = bsz * $urandom_range(1, 66);
            7:             len = $urandom_range(1, 32'(bsz / 4));
            default:       len = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                start = bsz * $urandom_range(0, 40);
                case ($urandom_range(0, 2))
                    0:       start = start;
                    1:       start = start + bsz - 1;
                    default: start = start + $urandom_range(0, 32'(bsz - 1));
                endcase
            end
            5, 6:    start = longint'({$urandom, $urandom}) & MAX_POS;
            7:       start = MAX_POS - $urandom_range(0, 32'(bsz));
            8:       start = longint'({$urandom, $urandom}) | ~MAX_POS;
            default: start = longint'({$urandom, $urandom});
        endcase
        r.wr  = $urandom_range(0, 1);
        r.ofs = start[DISP_W-1:0];
        r.len = len[LEN_W-1:0];
        kind  = $urandom_range(0, 99);
        if (kind < 35) begin
            r.op = sbas_pkg::OP_XFER_AT;
        end else if (kind < 60) begin
            r.op = sbas_pkg::OP_XFER_POS;
        end else if (kind < 72) begin
            r.op = sbas_pkg::OP_SEEK_SET;
        end else if (kind < 86) begin
            r.op  = sbas_pkg::OP_SEEK_CUR;
            r.ofs = DISP_W'(longint'($urandom_range(0, 32'(2 * bsz))) - bsz);
        end else if (kind < 97) begin
            r.op  = sbas_pkg::OP_SEEK_END;
            r.ofs = DISP_W'(-longint'($urandom_range(0, 32'(2 * bsz))));
        end else begin
            r.op = 3'(sbas_pkg::OP_SEEK_END) + 3'($urandom_range(1, 3));
        end
        return r;
    endfunction

    // Compares one field and reports a mismatch.
    function automatic void check_field(string field_name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s expected %h actual %h", $time, field_name, want, got);
        end
    endfunction

    task automatic check_result();
        segment_t got;
        segment_t want;
        got.phys    = m_tdata[57:0];
        got.seg_len = m_tdata[88:58];
        got.pos     = m_tdata[136:89];
        got.size    = m_tdata[184:137];
        got.seg_wr  = m_tuser[0];
        got.status  = sbas_pkg::status_t'(m_tuser[2:1]);
        got.last    = m_tlast;
        if (expected_segments.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, expected none actual physical_offset %h length %h",
                     $time, got.phys, got.seg_len);
            return;
        end
        want = expected_segments.pop_front();
        check_field("physical_offset", 64'(want.phys), 64'(got.phys));
        check_field("segment_length", 64'(want.seg_len), 64'(got.seg_len));
        check_field("segment_write", 64'(want.seg_wr), 64'(got.seg_wr));
        check_field("last_segment", 64'(want.last), 64'(got.last));
        check_field("status", 64'(want.status), 64'(got.status));
        check_field("position_now", 64'(want.pos), 64'(got.pos));
        check_field("size_now", 64'(want.size), 64'(got.size));
        results_checked++;
    endtask

    // Request driver: offers queued requests, predicting each one on its transfer.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                predict_request(offered);
                requests_accepted++;
                send_gap = $urandom_range(0, send_gap_max);
            end
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (request_queue.size() != 0) begin
                offered = request_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= S_TDATA_W'({offered.len, offered.ofs});
                s_tuser  <= {offered.wr, offered.op};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor: checks each transfer and paces m_tready.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_result();
                recv_gap = $urandom_range(0, recv_gap_max);
            end
            if (hold_served != hold_requests) begin
                hold_served++;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // One register write on the configuration channel; the mirror follows.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            sbas_pkg::CFG_BLOCK_LOG2: cfg_log2  = val[BSL_W-1:0];
            sbas_pkg::CFG_CHAN_COUNT: cfg_count = val;
            sbas_pkg::CFG_CHAN_INDEX: cfg_chan  = val[CI_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (request_queue.size() != 0 || s_tvalid || expected_segments.size() != 0);
    endtask

    // Sequencer: reset, directed requests, then random phases under new settings.
    initial begin
        int phase;
        int log2_val, count_val, index_val;
        cfg_log2       = 23;
        cfg_count      = 1;
        cfg_chan       = 0;
        position_model = '0;
        extent_model   = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed requests under the reset setting, with no idling.
        queue_request(sbas_pkg::OP_XFER_AT, 1'b1, 0, 0);
        queue_request(sbas_pkg::OP_XFER_AT, 1'b1, DEFAULT_BLOCK - 1, 2);
        queue_request(sbas_pkg::OP_XFER_AT, 1'b0, 3 * DEFAULT_BLOCK + 5, 64 * DEFAULT_BLOCK - 5);
        queue_request(sbas_pkg::OP_XFER_AT, 1'b1, 0, 64 * DEFAULT_BLOCK + 1);
        queue_request(sbas_pkg::OP_XFER_AT, 1'b0, 0, 32'hFFFF_FFFF);
        queue_request(sbas_pkg::OP_XFER_AT, 1'b1, -1, 10);
        queue_request(sbas_pkg::OP_XFER_AT, 1'b0, -MAX_POS - 1, 0);
        queue_request(sbas_pkg::OP_XFER_AT, 1'b1, MAX_POS, 0);
        queue_request(sbas_pkg::OP_XFER_AT, 1'b0, MAX_POS, 1);
        queue_request(sbas_pkg::OP_XFER_AT, 1'b1, MAX_POS - 100, 100);
        queue_request(sbas_pkg::OP_XFER_POS, 1'b1, 0, 100);
        queue_request(sbas_pkg::OP_XFER_POS, 1'b0, -1, DEFAULT_BLOCK - 8);
        queue_request(sbas_pkg::OP_SEEK_SET, 1'b0, 1000, 32'hFFFF_FFFF);
        queue_request(sbas_pkg::OP_SEEK_CUR, 1'b1, -500, 0);
        queue_request(sbas_pkg::OP_SEEK_CUR, 1'b0, -1000, 0);
        queue_request(sbas_pkg::OP_SEEK_END, 1'b0, 0, 0);
        queue_request(sbas_pkg::OP_SEEK_END, 1'b0, 1, 0);
        queue_request(sbas_pkg::OP_SEEK_SET, 1'b0, MAX_POS, 0);
        queue_request(sbas_pkg::OP_XFER_POS, 1'b1, 0, 0);
        queue_request(sbas_pkg::OP_XFER_POS, 1'b1, 0, 1);
        queue_request(sbas_pkg::OP_SEEK_SET, 1'b0, -1, 0);
        queue_request(sbas_pkg::OP_SEEK_SET, 1'b0, 0, 0);
        queue_request(3'(sbas_pkg::OP_SEEK_END) + 3'd1, 1'b1, 0, 0);
        queue_request(3'(sbas_pkg::OP_SEEK_END) + 3'd2, 1'b1, 0, 0);
        queue_request(3'(sbas_pkg::OP_SEEK_END) + 3'd3, 1'b1, 0, 0);
        settings_applied = 1;
        wait_idle();

        // Random phases; out-of-range register values exercise the clamps.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin
                    log2_val = 9;  count_val = 1024; index_val = 1023;
                    send_gap_max = 14; recv_gap_max = 14;
                end
                1: begin
                    log2_val = 30; count_val = 1;    index_val = 0;
                    send_gap_max = 0;  recv_gap_max = 0;
                end
                2: begin
                    log2_val = 12; count_val = 3;    index_val = 2;
                    send_gap_max = 0;  recv_gap_max = 14;
                end
                3: begin
                    log2_val = 0;  count_val = 0;    index_val = 5;
                    send_gap_max = 14; recv_gap_max = 14;
                end
                4: begin
                    log2_val = 31; count_val = 2047; index_val = 1023;
                    send_gap_max = 14; recv_gap_max = 0;
                end
                5: begin
                    log2_val = 10; count_val = 4;    index_val = 9;
                    send_gap_max = 0;  recv_gap_max = 14;
                end
                default: begin
                    log2_val = 23; count_val = 7;    index_val = 3;
                    send_gap_max = 14; recv_gap_max = 14;
                end
            endcase
            write_register(sbas_pkg::CFG_BLOCK_LOG2, CFG_DATA_W'(log2_val));
            write_register(sbas_pkg::CFG_CHAN_COUNT, CFG_DATA_W'(count_val));
            write_register(sbas_pkg::CFG_CHAN_INDEX, CFG_DATA_W'(index_val));
            settings_applied++;
            // Stall the receiver for a long stretch so the block backs up.
            if (phase == 2) hold_requests++;
            repeat (ITEMS_PER_PHASE) request_queue.push_back(random_request());
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(negedge aclk);
        $display("Covered %0d requests under %0d register settings: %0d rejected, %0d spanning.",
                 requests_accepted, settings_applied, rejected_requests, spanning_requests);
        $display("Checked %0d results with %0d mismatches.", results_checked, error_count);
        if (error_count == 0 && expected_segments.size() == 0) begin
            $display("striped_block_address_splitter_top regression: pass");
        end else begin
            $display("striped_block_address_splitter_top regression: fail");
        end
        $finish;
    end

    // Watchdog that ends a hung run as a failure.
    initial begin
        #8_000_000;
        $display("striped_block_address_splitter_top regression: fail");
        $finish;
    end

endmodule
